FILE: hw/rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types, sizes and helpers for the double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

   localparam int unsigned CAPACITY = 1024;
   localparam int unsigned IDX_W    = $clog2(CAPACITY);
   localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
   localparam int unsigned DATA_W   = 32;

   localparam logic [DATA_W-1:0] EMPTY_REPLY = '1;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_SIZE       = 3'd4,
      OP_EMPTY      = 3'd5,
      OP_FRONT      = 3'd6,
      OP_BACK       = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      REPLY_SIZE  = 2'd0,
      REPLY_FLAG  = 2'd1,
      REPLY_NONE  = 2'd2
   } reply_sel_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   typedef struct packed {
      logic          write_front;
      logic          write_back;
      logic          set_overflow;
      logic          drop_front;
      logic          drop_back;
      logic          read_front;
      logic          read_back;
      logic          load_imm;
      logic          load_mem;
      reply_sel_type imm_sel;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } status_type;

   // pos is below 2 * CAPACITY
   function automatic logic [IDX_W-1:0] wrap_slot(input logic [CNT_W:0] pos);
      logic [CNT_W:0] cap;
      logic [CNT_W:0] res;
      cap = (CNT_W + 1)'(CAPACITY);
      res = (pos >= cap) ? pos - cap : pos;
      return res[IDX_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/dq_if.sv
// ----------------------------------------------------------------------------
// dq_req_if / dq_rsp_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface dq_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         opcode;
   logic signed [31:0] push_value;

   modport source (output valid, output opcode, output push_value, input ready);
   modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface dq_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] reply_value;
   logic               overflowed;

   modport source (output valid, output reply_value, output overflowed, input ready);
   modport sink   (input valid, input reply_value, input overflowed, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/double_ended_queue.sv
// Results: a push gives no result word; size, empty and pops/peeks of an empty deque
//   are registered at acceptance; other pops/peeks pass through the slot read register.
// Throughput: one command word per cycle while result words are taken, except pops/peeks
//   of a non-empty deque, which also spend a read state moving the slot into the result.
// Reset: synchronous; clears pointers, count, overflow flag; slots are not cleared.
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue of signed 32-bit values in a circular slot memory.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue (
   input  wire logic clock,
   input  wire logic reset,
   dq_req_if.sink    req_if,
   dq_rsp_if.source  rsp_if
);

   // Command and status bundles between the controller and the datapath.
   dq_pkg::cmd_type    cmd;
   dq_pkg::status_type status;

   // The controller owns the handshakes: it takes a command word only when
   // the result register is free or being emptied this cycle, so a result
   // word never gets overwritten before it is taken.
   dq_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_opcode (req_if.opcode),
      .req_ready  (req_if.ready),
      .rsp_valid  (rsp_if.valid),
      .rsp_ready  (rsp_if.ready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the slot memory, head index, count, sticky overflow
   // flag and the result register. Pushes write at accept; pops update the
   // pointers at accept, and the slot read is registered, then copied to the result.
   dq_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .push_value  (req_if.push_value),
      .status      (status),
      .reply_value (rsp_if.reply_value),
      .overflowed  (rsp_if.overflowed)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/dq_datapath.sv
// ----------------------------------------------------------------------------
// dq_datapath
// Slot memory, head/count pointers, overflow flag and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dq_pkg::cmd_type               cmd,
   input  wire logic [dq_pkg::DATA_W-1:0]     push_value,
   output dq_pkg::status_type                 status,
   output logic [dq_pkg::DATA_W-1:0]          reply_value,
   output logic                               overflowed
);

   logic [dq_pkg::DATA_W-1:0] mem [dq_pkg::CAPACITY];

   logic [dq_pkg::IDX_W-1:0]  head_ff, head_in;
   logic [dq_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                      ovf_ff, ovf_in;
   logic [dq_pkg::DATA_W-1:0] rd_ff;
   logic [dq_pkg::DATA_W-1:0] reply_ff, reply_in;
   logic                      rovf_ff, rovf_in;

   logic [dq_pkg::IDX_W-1:0]  head_dec;
   logic [dq_pkg::IDX_W-1:0]  head_inc;
   logic [dq_pkg::IDX_W-1:0]  tail_slot;   // first free slot past the back
   logic [dq_pkg::IDX_W-1:0]  back_slot;
   logic [dq_pkg::IDX_W-1:0]  waddr;
   logic [dq_pkg::IDX_W-1:0]  raddr;
   logic [dq_pkg::DATA_W-1:0] imm_value;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == dq_pkg::CNT_W'(dq_pkg::CAPACITY));

   always_comb begin
      head_dec  = (head_ff == '0) ? dq_pkg::IDX_W'(dq_pkg::CAPACITY - 1) : head_ff - 1'b1;
      head_inc  = dq_pkg::wrap_slot((dq_pkg::CNT_W + 1)'(head_ff) + 1'b1);
      tail_slot = dq_pkg::wrap_slot((dq_pkg::CNT_W + 1)'(head_ff)
                                    + (dq_pkg::CNT_W + 1)'(count_ff));
      back_slot = dq_pkg::wrap_slot((dq_pkg::CNT_W + 1)'(head_ff)
                                    + (dq_pkg::CNT_W + 1)'(count_ff) - 1'b1);
      waddr     = cmd.write_front ? head_dec : tail_slot;
      raddr     = cmd.read_front ? head_ff : back_slot;
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff | cmd.set_overflow;
      if (cmd.write_front) begin
         head_in  = head_dec;
         count_in = count_ff + 1'b1;
      end else if (cmd.write_back) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.drop_front) begin
         head_in  = head_inc;
         count_in = count_ff - 1'b1;
      end else if (cmd.drop_back) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      case (cmd.imm_sel)
         dq_pkg::REPLY_SIZE: imm_value = dq_pkg::DATA_W'(count_ff);
         dq_pkg::REPLY_FLAG: imm_value = dq_pkg::DATA_W'(status.empty);
         default:            imm_value = dq_pkg::EMPTY_REPLY;
      endcase
   end

   always_comb begin
      reply_in = reply_ff;
      rovf_in  = rovf_ff;
      if (cmd.load_imm) begin
         reply_in = imm_value;
         rovf_in  = ovf_ff;
      end else if (cmd.load_mem) begin
         reply_in = rd_ff;
         rovf_in  = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_front || cmd.write_back) begin
         mem[waddr] <= push_value;
      end
      if (cmd.read_front || cmd.read_back) begin
         rd_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      reply_ff <= reply_in;
      rovf_ff  <= rovf_in;
   end

   assign reply_value = reply_ff;
   assign overflowed  = rovf_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/dq_controller.sv
// ----------------------------------------------------------------------------
// dq_controller
// Command decode, read sequencing and result handshake control.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_controller (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic [2:0]         req_opcode,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire dq_pkg::status_type status,
   output dq_pkg::cmd_type         cmd
);

   dq_pkg::state_type state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   dq_pkg::op_type    op;

   assign op        = dq_pkg::op_type'(req_opcode);
   assign req_ready = (state_ff == dq_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dq_pkg::ST_IDLE: begin
            if (accept && !status.empty &&
                (op inside {dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK,
                            dq_pkg::OP_FRONT, dq_pkg::OP_BACK})) begin
               state_in = dq_pkg::ST_READ;
            end
         end
         dq_pkg::ST_READ: state_in = dq_pkg::ST_IDLE;
         default:         state_in = dq_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd         = '0;
      cmd.imm_sel = dq_pkg::REPLY_NONE;
      case (state_ff)
         dq_pkg::ST_IDLE: begin
            if (accept) begin
               case (op)
                  dq_pkg::OP_PUSH_FRONT: begin
                     cmd.set_overflow = status.full;
                     cmd.write_front  = !status.full;
                  end
                  dq_pkg::OP_PUSH_BACK: begin
                     cmd.set_overflow = status.full;
                     cmd.write_back   = !status.full;
                  end
                  dq_pkg::OP_POP_FRONT: begin
                     cmd.load_imm   = status.empty;
                     cmd.read_front = !status.empty;
                     cmd.drop_front = !status.empty;
                  end
                  dq_pkg::OP_POP_BACK: begin
                     cmd.load_imm  = status.empty;
                     cmd.read_back = !status.empty;
                     cmd.drop_back = !status.empty;
                  end
                  dq_pkg::OP_FRONT: begin
                     cmd.load_imm   = status.empty;
                     cmd.read_front = !status.empty;
                  end
                  dq_pkg::OP_BACK: begin
                     cmd.load_imm  = status.empty;
                     cmd.read_back = !status.empty;
                  end
                  dq_pkg::OP_SIZE: begin
                     cmd.load_imm = 1'b1;
                     cmd.imm_sel  = dq_pkg::REPLY_SIZE;
                  end
                  dq_pkg::OP_EMPTY: begin
                     cmd.load_imm = 1'b1;
                     cmd.imm_sel  = dq_pkg::REPLY_FLAG;
                  end
                  default: cmd = '0;
               endcase
            end
         end
         dq_pkg::ST_READ: cmd.load_mem = 1'b1;
         default:         cmd = '0;
      endcase
   end

   always_comb begin
      if (cmd.load_imm || cmd.load_mem) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_port_checker
// Port-level assertions for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_port_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_overflowed
);

   logic seen_ovf_ff, seen_ovf_in;
   logic req_acc;

   assign req_acc     = req_valid && req_ready;
   assign seen_ovf_in = seen_ovf_ff | (rsp_valid && rsp_ready && rsp_overflowed);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ovf_ff <= 1'b0;
      end else begin
         seen_ovf_ff <= seen_ovf_in;
      end
   end

   // result word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped before taken");

   // no new command while a result is stalled
   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("command taken while result stalled");

   // overflow flag is sticky across result words
   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_ovf_ff |-> rsp_overflowed)
      else $error("overflow flag cleared");

   // a fresh result word is caused by an accepted command, directly or via a slot read
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_acc) || $past(req_acc, 2))
      else $error("result word without command");

endmodule

bind double_ended_queue dq_port_checker u_dq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_overflowed (rsp_if.overflowed)
);

`default_nettype wire
